@@ rtl/kpc_pkg.sv @@
// Shared types and constants for the key press classifier.
package kpc_pkg;

   localparam int unsigned TICKS_WIDTH = 15;
   localparam int unsigned HOLD_WIDTH  = 16;

   localparam logic [HOLD_WIDTH-1:0] CLAMP_MARGIN = 16'd50;

   typedef logic [TICKS_WIDTH-1:0] ticks_type;
   typedef logic [HOLD_WIDTH-1:0]  hold_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2,
      EV_VLONG = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_PRESS = 3'b010,
      PH_HOLD  = 3'b100
   } phase_type;

   typedef enum logic {
      CSR_LONG_TICKS  = 1'b0,
      CSR_VLONG_TICKS = 1'b1
   } csr_index_type;

endpackage

@@ rtl/key_press_classifier.sv @@
// Key press classifier: short / long / very long press detection and power state.
//
// Usage:
//  - req channel: one item per tick carrying req_key_level (0 = key pressed).
//    Accepted when req_valid is high and req_stall is low.
//  - rsp channel: exactly one result per accepted item: event code, power
//    state, power-up and frame-request pulses, sticky unlocked flag.
//  - csr port: csr_write_enable with csr_index 0 writes the long press
//    threshold, index 1 the very long press threshold (15 bits each).
//    Write only while no item is in flight.
// Output: an item's result is registered and shown in the cycle after acceptance.
// Throughput: one item per cycle while req_stall is low; the whole tick update
// is a single pass of logic from the state registers into the result register.
// Stall: while rsp_stall holds a waiting result, req_stall is raised; the
// result register frees up in the same cycle it is taken, so a new item can
// be accepted on that edge.
// Reset: clears press phase, hold count, lock, power (off), unlocked flag,
// and restores thresholds to 200 and 1000 ticks. No result is pending.
module key_press_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_key_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_code,
   output logic       rsp_power_on,
   output logic       rsp_power_up_pulse,
   output logic       rsp_send_frame_pulse,
   output logic       rsp_unlocked,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [kpc_pkg::TICKS_WIDTH-1:0] csr_write_data
);

   kpc_pkg::ticks_type long_ticks_ff, vlong_ticks_ff;
   kpc_pkg::phase_type phase_ff, phase_in;
   kpc_pkg::hold_type  hold_ff, hold_in;
   logic lock_ff, lock_in;
   logic power_ff, power_in;
   logic unlock_ff, unlock_in;

   logic rsp_valid_ff;
   kpc_pkg::event_type rsp_event_ff;
   logic rsp_power_ff, rsp_up_ff, rsp_frame_ff, rsp_unlock_ff;

   kpc_pkg::event_type ev;
   kpc_pkg::hold_type  hold_inc, long16, vlong16;
   logic pressed, accept, up, frame;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign pressed   = ~req_key_level;
   assign hold_inc  = hold_ff + kpc_pkg::HOLD_WIDTH'(1);
   assign long16    = {1'b0, long_ticks_ff};
   assign vlong16   = {1'b0, vlong_ticks_ff};

   always_comb begin
      phase_in = phase_ff;
      hold_in  = hold_ff;
      lock_in  = lock_ff;
      ev       = kpc_pkg::EV_NONE;
      unique case (phase_ff)
         kpc_pkg::PH_PRESS: begin
            phase_in = pressed ? kpc_pkg::PH_HOLD : kpc_pkg::PH_IDLE;
            hold_in  = '0;
         end
         kpc_pkg::PH_HOLD: begin
            if (!pressed) begin
               phase_in = kpc_pkg::PH_IDLE;
               if (hold_ff < long16) begin
                  ev = kpc_pkg::EV_SHORT;
               end
               hold_in = '0;
               lock_in = 1'b0;
            end else begin
               hold_in = hold_inc;
               if (hold_inc >= long16) begin
                  if (hold_inc == long16) begin
                     ev = kpc_pkg::EV_LONG;
                     if (power_ff) begin
                        lock_in = 1'b1;
                     end
                  end
                  if (lock_in) begin
                     if (hold_inc == vlong16) begin
                        ev = kpc_pkg::EV_VLONG;
                     end
                     if (hold_inc >= vlong16) begin
                        hold_in = vlong16 + kpc_pkg::CLAMP_MARGIN;
                     end
                  end else begin
                     hold_in = long16 + kpc_pkg::CLAMP_MARGIN;
                  end
               end
            end
         end
         default: begin
            phase_in = pressed ? kpc_pkg::PH_PRESS : kpc_pkg::PH_IDLE;
         end
      endcase
   end

   always_comb begin
      power_in  = power_ff;
      unlock_in = unlock_ff;
      up        = 1'b0;
      frame     = 1'b0;
      unique case (ev)
         kpc_pkg::EV_SHORT: begin
            if (!power_ff) begin
               power_in = 1'b1;
               up       = 1'b1;
            end else begin
               frame = 1'b1;
            end
         end
         kpc_pkg::EV_LONG: begin
            power_in = ~power_ff;
            up       = ~power_ff;
         end
         kpc_pkg::EV_VLONG: begin
            unlock_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff  <= kpc_pkg::TICKS_WIDTH'(200);
         vlong_ticks_ff <= kpc_pkg::TICKS_WIDTH'(1000);
      end else if (csr_write_enable) begin
         unique case (kpc_pkg::csr_index_type'(csr_index))
            kpc_pkg::CSR_LONG_TICKS:  long_ticks_ff  <= csr_write_data;
            kpc_pkg::CSR_VLONG_TICKS: vlong_ticks_ff <= csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= kpc_pkg::PH_IDLE;
         hold_ff      <= '0;
         lock_ff      <= 1'b0;
         power_ff     <= 1'b0;
         unlock_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            hold_ff   <= hold_in;
            lock_ff   <= lock_in;
            power_ff  <= power_in;
            unlock_ff <= unlock_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff  <= ev;
         rsp_power_ff  <= power_in;
         rsp_up_ff     <= up;
         rsp_frame_ff  <= frame;
         rsp_unlock_ff <= unlock_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_code       = rsp_event_ff;
   assign rsp_power_on         = rsp_power_ff;
   assign rsp_power_up_pulse   = rsp_up_ff;
   assign rsp_send_frame_pulse = rsp_frame_ff;
   assign rsp_unlocked         = rsp_unlock_ff;

endmodule

@@ rtl/kpc_checker.sv @@
// Port-level assertions for the key press classifier, bound to the top level.
module kpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_code,
   input logic       rsp_power_on,
   input logic       rsp_power_up_pulse,
   input logic       rsp_send_frame_pulse,
   input logic       rsp_unlocked
);

   // stalled result stays valid and keeps event code, power state and unlocked flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_power_on) && $stable(rsp_unlocked))
      else $error("stalled result changed");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   a_vlong_unlocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == kpc_pkg::EV_VLONG |-> rsp_unlocked)
      else $error("very long press without unlocked flag");

   a_power_up_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_power_up_pulse |-> rsp_power_on
         && (rsp_event_code == kpc_pkg::EV_SHORT || rsp_event_code == kpc_pkg::EV_LONG))
      else $error("power-up pulse without power on");

   a_frame_short_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_frame_pulse |-> rsp_power_on && !rsp_power_up_pulse
         && rsp_event_code == kpc_pkg::EV_SHORT)
      else $error("frame request outside short press with power on");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_event_code       (rsp_event_code),
   .rsp_power_on         (rsp_power_on),
   .rsp_power_up_pulse   (rsp_power_up_pulse),
   .rsp_send_frame_pulse (rsp_send_frame_pulse),
   .rsp_unlocked         (rsp_unlocked)
);

@@ test/key_press_checker.sv @@
`timescale 1ns / 1ps
// Key press classifier checker: watches both channels, predicts each tick's result and compares.
module key_press_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_key_level,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_event_code,
   input  logic               rsp_power_on,
   input  logic               rsp_power_up_pulse,
   input  logic               rsp_send_frame_pulse,
   input  logic               rsp_unlocked,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  kpc_pkg::ticks_type csr_write_data,
   output int                 mismatches,
   output int                 outstanding
);

   typedef struct packed {
      kpc_pkg::event_type code;
      logic               power_on;
      logic               power_up;
      logic               frame;
      logic               unlocked;
   } tick_result_type;

   kpc_pkg::ticks_type long_ticks;
   kpc_pkg::ticks_type vlong_ticks;
   kpc_pkg::phase_type phase;
   kpc_pkg::hold_type  hold;
   logic               lock_armed;
   logic               power;
   logic               unlock;
   tick_result_type    awaited[$];
   int                 results_seen = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d %s = %0d, predicted %0d",
                                   results_seen, name, got, want));
      end
   endtask

   // One tick of the press detector followed by the power logic.
   task automatic step_key(input logic key_level, output tick_result_type res);
      logic               pressed;
      kpc_pkg::event_type ev;
      logic               up;
      logic               frame;
      pressed = !key_level;
      ev      = kpc_pkg::EV_NONE;
      up      = 1'b0;
      frame   = 1'b0;
      case (phase)
         kpc_pkg::PH_PRESS: begin
            phase = pressed ? kpc_pkg::PH_HOLD : kpc_pkg::PH_IDLE;
            hold  = '0;
         end
         kpc_pkg::PH_HOLD: begin
            if (!pressed) begin
               phase = kpc_pkg::PH_IDLE;
               if (hold < kpc_pkg::hold_type'(long_ticks)) ev = kpc_pkg::EV_SHORT;
               hold       = '0;
               lock_armed = 1'b0;
            end else begin
               hold = hold + kpc_pkg::hold_type'(1);
               if (hold >= kpc_pkg::hold_type'(long_ticks)) begin
                  if (hold == kpc_pkg::hold_type'(long_ticks)) begin
                     ev = kpc_pkg::EV_LONG;
                     if (power) lock_armed = 1'b1;
                  end
                  if (lock_armed) begin
                     if (hold == kpc_pkg::hold_type'(vlong_ticks)) ev = kpc_pkg::EV_VLONG;
                     if (hold >= kpc_pkg::hold_type'(vlong_ticks)) begin
                        hold = kpc_pkg::hold_type'(vlong_ticks) + kpc_pkg::CLAMP_MARGIN;
                     end
                  end else begin
                     hold = kpc_pkg::hold_type'(long_ticks) + kpc_pkg::CLAMP_MARGIN;
                  end
               end
            end
         end
         default: phase = pressed ? kpc_pkg::PH_PRESS : kpc_pkg::PH_IDLE;
      endcase
      case (ev)
         kpc_pkg::EV_SHORT: begin
            if (!power) begin
               power = 1'b1;
               up    = 1'b1;
            end else begin
               frame = 1'b1;
            end
         end
         kpc_pkg::EV_LONG: begin
            power = !power;
            up    = power;
         end
         kpc_pkg::EV_VLONG: unlock = 1'b1;
         default: ;
      endcase
      res.code     = ev;
      res.power_on = power;
      res.power_up = up;
      res.frame    = frame;
      res.unlocked = unlock;
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         mismatches  = 0;
         long_ticks  = 15'd200;
         vlong_ticks = 15'd1000;
         phase       = kpc_pkg::PH_IDLE;
         hold        = '0;
         lock_armed  = 1'b0;
         power       = 1'b0;
         unlock      = 1'b0;
         awaited.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               kpc_pkg::CSR_LONG_TICKS:  long_ticks  = csr_write_data;
               kpc_pkg::CSR_VLONG_TICKS: vlong_ticks = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no item waiting",
                                         results_seen));
            end else begin
               want = awaited.pop_front();
               check_field("event_code", rsp_event_code, want.code);
               check_field("power_on", {1'b0, rsp_power_on}, {1'b0, want.power_on});
               check_field("power_up_pulse", {1'b0, rsp_power_up_pulse},
                           {1'b0, want.power_up});
               check_field("send_frame_pulse", {1'b0, rsp_send_frame_pulse},
                           {1'b0, want.frame});
               check_field("unlocked", {1'b0, rsp_unlocked}, {1'b0, want.unlocked});
            end
            results_seen++;
         end
         if (req_valid && !req_stall) begin
            step_key(req_key_level, want);
            awaited.push_back(want);
         end
      end
      outstanding = awaited.size();
   end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the key press classifier: stimulus, threshold settings and verdict.
module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTINGS_N  = 9;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_key_level;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_event_code;
   logic               rsp_power_on;
   logic               rsp_power_up_pulse;
   logic               rsp_send_frame_pulse;
   logic               rsp_unlocked;
   logic               csr_write_enable;
   logic               csr_index;
   kpc_pkg::ticks_type csr_write_data;

   int   mismatches;
   int   outstanding;
   int   cycles = 0;
   int   items_sent = 0;
   int   send_idle_pct;
   int   recv_stall_pct;
   logic hold_off_request;
   int   long_t;
   int   vlong_t;
   int   long_list[SETTINGS_N];
   int   vlong_list[SETTINGS_N];

   // short presses, a one-tick glitch and an immediate re-press
   localparam logic [15:0] DIRECTED_KEYS = 16'b1010000100011001;

   key_press_classifier dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_key_level        (req_key_level),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_code       (rsp_event_code),
      .rsp_power_on         (rsp_power_on),
      .rsp_power_up_pulse   (rsp_power_up_pulse),
      .rsp_send_frame_pulse (rsp_send_frame_pulse),
      .rsp_unlocked         (rsp_unlocked),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   key_press_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_key_level        (req_key_level),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_code       (rsp_event_code),
      .rsp_power_on         (rsp_power_on),
      .rsp_power_up_pulse   (rsp_power_up_pulse),
      .rsp_send_frame_pulse (rsp_send_frame_pulse),
      .rsp_unlocked         (rsp_unlocked),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      logic hold_off_done;
      hold_off_done = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (150) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_key(input logic level);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_key_level <= level;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_press(input int gap, input int len);
      repeat (gap) send_key(1'b1);
      repeat (len) send_key(1'b0);
   endtask

   task automatic run_presses(input int budget);
      int first;
      int len;
      first = items_sent;
      while (items_sent - first < budget) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_key(1'($urandom_range(0, 1)));
         end else begin
            case ($urandom_range(0, 2))
               0: len = $urandom_range(1, long_t + 1);
               1: len = $urandom_range(long_t + 1, vlong_t + 4);
               default: len = $urandom_range(1, 150);
            endcase
            if (len > 150) len = $urandom_range(2, 150);
            send_press($urandom_range(1, 4), len);
         end
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic apply_thresholds(input int lt, input int vt);
      csr_write_enable <= 1'b1;
      csr_index        <= kpc_pkg::CSR_LONG_TICKS;
      csr_write_data   <= kpc_pkg::ticks_type'(lt);
      @(negedge clock);
      csr_index        <= kpc_pkg::CSR_VLONG_TICKS;
      csr_write_data   <= kpc_pkg::ticks_type'(vt);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      long_t  = lt;
      vlong_t = vt;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_key_level    = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = kpc_pkg::CSR_LONG_TICKS;
      csr_write_data   = '0;
      send_idle_pct    = 37;
      recv_stall_pct   = 84;
      hold_off_request = 1'b0;
      long_t           = 200;
      vlong_t          = 1000;
      long_list  = '{1, 3, 6, 0, 32767, 2, 5, 2, 0};
      vlong_list = '{2, 3, 3, 5, 32767, 20, 1, 0, 0};
      long_list[5]  = $urandom_range(2, 10);
      vlong_list[5] = $urandom_range(11, 40);
      long_list[8]  = $urandom_range(1, 15);
      vlong_list[8] = $urandom_range(1, 30);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds: directed presses, then one long press and one short press
      for (int i = 15; i >= 0; i--) send_key(DIRECTED_KEYS[i]);
      send_press(2, $urandom_range(202, 230));
      send_press(1, 4);
      drain();

      for (int s = 0; s < SETTINGS_N; s++) begin
         if (s < 3) begin
            send_idle_pct  = 37;
            recv_stall_pct = 84;
         end else if (s < 6) begin
            send_idle_pct  = 84;
            recv_stall_pct = 37;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         apply_thresholds(long_list[s], vlong_list[s]);
         if (s == 6) hold_off_request = 1'b1;
         run_presses(125);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/kpc_pkg.sv
rtl/key_press_classifier.sv
rtl/kpc_checker.sv
test/key_press_checker.sv
test/tb.sv
